/* rtl/spd_pkg.sv */
// spd_pkg: types, codes, default parameters and the fixed signal class table
// for the pending-signal dispatcher. No dependencies.
`default_nettype none

package spd_pkg;

   // Field widths
   localparam int MODE_W    = 2;
   localparam int SIG_W     = 5;
   localparam int DISP_W    = 2;
   localparam int ACTION_W  = 3;
   localparam int CLASS_W   = 3;
   localparam int PEND_OUT_W = 20;

   // Default signal numbering
   localparam int NUM_SIGNALS_DEF  = 19;
   localparam int CHILD_SIGNAL_DEF = 18;
   localparam int KILL_SIGNAL_DEF  = 9;
   localparam int STOP_SIGNAL_DEF  = 19;

   typedef enum logic [MODE_W-1:0] {
      MODE_POST     = 2'd0,
      MODE_SET_DISP = 2'd1,
      MODE_CHECK    = 2'd2,
      MODE_DELIVER  = 2'd3
   } mode_type;

   // Dispositions
   localparam logic [DISP_W-1:0] DISP_DEFAULT = 2'd0;
   localparam logic [DISP_W-1:0] DISP_IGNORE  = 2'd1;
   localparam logic [DISP_W-1:0] DISP_CATCH   = 2'd2;

   // Deliver actions
   localparam logic [ACTION_W-1:0] ACT_NONE      = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_IGNORED   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_HANDLER   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_CORE_EXIT = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_EXIT      = 3'd4;

   // Signal classes
   localparam logic [CLASS_W-1:0] CLS_NONE      = 3'd0;
   localparam logic [CLASS_W-1:0] CLS_TTY       = 3'd1;
   localparam logic [CLASS_W-1:0] CLS_EXCEPTION = 3'd2;
   localparam logic [CLASS_W-1:0] CLS_TRACE     = 3'd3;
   localparam logic [CLASS_W-1:0] CLS_TERM      = 3'd4;
   localparam logic [CLASS_W-1:0] CLS_SYSERR    = 3'd5;
   localparam logic [CLASS_W-1:0] CLS_USER      = 3'd6;

   typedef struct packed {
      mode_type           mode;
      logic [SIG_W-1:0]   signal_number;
      logic [DISP_W-1:0]  disposition;
   } req_item_type;

   typedef struct packed {
      logic                  error;
      logic                  deliverable;
      logic [SIG_W-1:0]      signal_out;
      logic [ACTION_W-1:0]   action;
      logic [CLASS_W-1:0]    signal_class;
      logic                  reap_children;
      logic [PEND_OUT_W-1:0] pending_after;
   } rsp_item_type;

   // Core-dump flag (msb) and class of each signal number
   function automatic logic [CLASS_W:0] sig_info(input logic [SIG_W-1:0] sig);
      logic [CLASS_W:0] info;
      case (sig)
         5'd1:    info = {1'b0, CLS_TTY};
         5'd2:    info = {1'b0, CLS_TTY};
         5'd3:    info = {1'b1, CLS_TTY};
         5'd4:    info = {1'b1, CLS_EXCEPTION};
         5'd5:    info = {1'b1, CLS_TRACE};
         5'd6:    info = {1'b1, CLS_EXCEPTION};
         5'd7:    info = {1'b1, CLS_EXCEPTION};
         5'd8:    info = {1'b1, CLS_EXCEPTION};
         5'd9:    info = {1'b0, CLS_TERM};
         5'd10:   info = {1'b1, CLS_EXCEPTION};
         5'd11:   info = {1'b1, CLS_EXCEPTION};
         5'd12:   info = {1'b1, CLS_SYSERR};
         5'd13:   info = {1'b0, CLS_SYSERR};
         5'd14:   info = {1'b0, CLS_USER};
         5'd15:   info = {1'b0, CLS_TERM};
         5'd16:   info = {1'b0, CLS_USER};
         5'd17:   info = {1'b0, CLS_USER};
         5'd18:   info = {1'b0, CLS_TERM};
         5'd19:   info = {1'b0, CLS_TTY};
         default: info = {1'b0, CLS_NONE};
      endcase
      return info;
   endfunction

endpackage

`default_nettype wire

/* rtl/spd_req_if.sv */
// spd_req_if: request channel of the pending-signal dispatcher.
// Depends on spd_pkg for field widths.
`default_nettype none

interface spd_req_if;
   import spd_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [SIG_W-1:0]  signal_number;
   logic [DISP_W-1:0] disposition;

   modport source (output valid, output mode, output signal_number, output disposition,
                   input ready);
   modport sink   (input valid, input mode, input signal_number, input disposition,
                   output ready);
endinterface

`default_nettype wire

/* rtl/spd_rsp_if.sv */
// spd_rsp_if: response channel of the pending-signal dispatcher.
// Depends on spd_pkg for field widths.
`default_nettype none

interface spd_rsp_if;
   import spd_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  error;
   logic                  deliverable;
   logic [SIG_W-1:0]      signal_out;
   logic [ACTION_W-1:0]   action;
   logic [CLASS_W-1:0]    signal_class;
   logic                  reap_children;
   logic [PEND_OUT_W-1:0] pending_after;

   modport source (output valid, output error, output deliverable, output signal_out,
                   output action, output signal_class, output reap_children,
                   output pending_after, input ready);
   modport sink   (input valid, input error, input deliverable, input signal_out,
                   input action, input signal_class, input reap_children,
                   input pending_after, output ready);
endinterface

`default_nettype wire

/* rtl/spd_eval.sv */
// spd_eval: single-pass evaluation of one item against the pending mask and
// disposition table; gives next state and the response. Depends on spd_pkg.
`default_nettype none

module spd_eval #(
   parameter int NUM_SIGNALS  = spd_pkg::NUM_SIGNALS_DEF,
   parameter int CHILD_SIGNAL = spd_pkg::CHILD_SIGNAL_DEF,
   parameter int KILL_SIGNAL  = spd_pkg::KILL_SIGNAL_DEF,
   parameter int STOP_SIGNAL  = spd_pkg::STOP_SIGNAL_DEF
) (
   input  spd_pkg::req_item_type                item_i,
   input  logic [NUM_SIGNALS:0]                 pend_i,
   input  logic [spd_pkg::DISP_W-1:0]           disp_i [NUM_SIGNALS+1],
   output logic [NUM_SIGNALS:0]                 pend_o,
   output logic [spd_pkg::DISP_W-1:0]           disp_o [NUM_SIGNALS+1],
   output spd_pkg::rsp_item_type                rsp_o
);
   import spd_pkg::*;

   localparam int NSIG = NUM_SIGNALS + 1;
   localparam logic [SIG_W-1:0] LAST_SIG = SIG_W'(NUM_SIGNALS);
   localparam logic [SIG_W-1:0] KILL_C   = SIG_W'(KILL_SIGNAL);
   localparam logic [SIG_W-1:0] STOP_C   = SIG_W'(STOP_SIGNAL);

   logic                  in_range;
   logic [NSIG-1:0]       sig_onehot;
   logic [NSIG-1:0]       drop;
   logic [NSIG-1:0]       keep;
   logic [NSIG-1:0]       reap_vec;
   logic [NSIG-1:0]       keep_low;
   logic [NSIG-1:0]       below;
   logic [NSIG-1:0]       pend_low;
   logic [SIG_W-1:0]      low_idx;
   logic [DISP_W-1:0]     low_disp;
   logic [CLASS_W:0]      low_info;
   logic [DISP_W-1:0]     disp_wr;
   logic [PEND_OUT_W+NSIG-1:0] pend_ext;
   rsp_item_type          rsp_core;

   assign in_range = (item_i.signal_number != '0) && (item_i.signal_number <= LAST_SIG);
   // Code three is kept as catch
   assign disp_wr  = (item_i.disposition == DISP_DEFAULT ||
                      item_i.disposition == DISP_IGNORE) ? item_i.disposition : DISP_CATCH;

   // Per-signal decode: which pending signals a check would drop
   always_comb begin
      for (int i = 0; i < NSIG; i++) begin
         sig_onehot[i] = (item_i.signal_number == SIG_W'(i));
         if (i == CHILD_SIGNAL) begin
            drop[i] = pend_i[i] & ((disp_i[i] == DISP_IGNORE) || (disp_i[i] == DISP_DEFAULT));
         end else begin
            drop[i] = pend_i[i] & (disp_i[i] == DISP_IGNORE);
         end
         reap_vec[i] = pend_i[i] & (i == CHILD_SIGNAL) & (disp_i[i] == DISP_IGNORE);
      end
   end

   // Lowest deliverable signal bounds what a check may drop
   assign keep     = pend_i & ~drop;
   assign keep_low = keep & (~keep + NSIG'(1));
   assign below    = (keep == '0) ? '1 : (keep_low - NSIG'(1));
   assign pend_low = pend_i & (~pend_i + NSIG'(1));

   // Encode the lowest pending signal and fetch its disposition
   always_comb begin
      low_idx  = '0;
      low_disp = DISP_DEFAULT;
      for (int i = 0; i < NSIG; i++) begin
         if (pend_low[i]) begin
            low_idx  = low_idx | SIG_W'(i);
            low_disp = low_disp | disp_i[i];
         end
      end
   end

   assign low_info = sig_info(low_idx);

   // Mode decode and state update
   always_comb begin
      pend_o   = pend_i;
      disp_o   = disp_i;
      rsp_core = '0;
      case (item_i.mode)
         MODE_POST: begin
            if (in_range) begin
               pend_o = pend_i | sig_onehot;
            end else begin
               rsp_core.error = 1'b1;
            end
         end
         MODE_SET_DISP: begin
            if (!in_range || item_i.signal_number == KILL_C ||
                item_i.signal_number == STOP_C) begin
               rsp_core.error = 1'b1;
            end else begin
               for (int i = 0; i < NSIG; i++) begin
                  if (sig_onehot[i]) begin
                     disp_o[i] = disp_wr;
                  end
               end
            end
         end
         MODE_CHECK: begin
            pend_o                 = pend_i & ~(drop & below);
            rsp_core.deliverable   = |keep;
            rsp_core.reap_children = |(reap_vec & below);
         end
         MODE_DELIVER: begin
            if (pend_i != '0) begin
               pend_o                = pend_i & ~pend_low;
               rsp_core.signal_out   = low_idx;
               rsp_core.signal_class = low_info[CLASS_W-1:0];
               if (low_disp == DISP_IGNORE) begin
                  rsp_core.action = ACT_IGNORED;
               end else if (low_disp != DISP_DEFAULT) begin
                  rsp_core.action = ACT_HANDLER;
                  for (int i = 0; i < NSIG; i++) begin
                     if (pend_low[i]) begin
                        disp_o[i] = DISP_DEFAULT;
                     end
                  end
               end else if (low_info[CLASS_W]) begin
                  rsp_core.action = ACT_CORE_EXIT;
               end else begin
                  rsp_core.action = ACT_EXIT;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Reported mask is a fixed 20 bits wide
   assign pend_ext = {{PEND_OUT_W{1'b0}}, pend_o};

   always_comb begin
      rsp_o               = rsp_core;
      rsp_o.pending_after = pend_ext[PEND_OUT_W-1:0];
   end

endmodule

`default_nettype wire

/* rtl/signal_pending_dispatcher.sv */
// signal_pending_dispatcher: top level of the pending-signal dispatcher.
// Depends on spd_pkg, spd_req_if, spd_rsp_if and spd_eval.
//
// Requests arrive on req_if (valid/ready): mode, signal_number, disposition.
// Each request gives exactly one response on rsp_if (valid/ready) carrying
// error, deliverable, signal_out, action, signal_class, reap_children and
// the pending mask after the request.
// A transfer lands in an input register; an edge on which the response
// register is free or being taken evaluates it against the pending mask and
// disposition table in one pass and loads the response register, updating
// the state on that same edge. Throughput is one request per cycle while the
// receiver does not stall, set by the combinational evaluation in spd_eval.
// When the receiver stalls, the held response blocks the input register,
// which still takes one more request; req_if.ready then drops until the
// response is taken.
// Synchronous reset clears the pending mask, sets every disposition to
// default and empties both registers; a request may follow straight away.
`default_nettype none

module signal_pending_dispatcher #(
   parameter int NUM_SIGNALS  = spd_pkg::NUM_SIGNALS_DEF,
   parameter int CHILD_SIGNAL = spd_pkg::CHILD_SIGNAL_DEF,
   parameter int KILL_SIGNAL  = spd_pkg::KILL_SIGNAL_DEF,
   parameter int STOP_SIGNAL  = spd_pkg::STOP_SIGNAL_DEF
) (
   input logic       clock,
   input logic       reset,
   spd_req_if.sink   req_if,
   spd_rsp_if.source rsp_if
);
   import spd_pkg::*;

   localparam int NSIG = NUM_SIGNALS + 1;

   logic               req_valid_ff, req_valid_in;
   req_item_type       req_item_ff, req_item_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff;
   logic [NSIG-1:0]    pend_ff;
   logic [DISP_W-1:0]  disp_ff [NSIG];

   logic               advance;
   logic [NSIG-1:0]    pend_next;
   logic [DISP_W-1:0]  disp_next [NSIG];
   rsp_item_type       rsp_next;

   // Handshake control
   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !req_valid_ff || advance;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_item_in  = req_item_ff;
      if (req_if.ready) begin
         req_valid_in = req_if.valid;
         req_item_in  = '{mode:          mode_type'(req_if.mode),
                          signal_number: req_if.signal_number,
                          disposition:   req_if.disposition};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
      req_item_ff <= req_item_in;
   end

   spd_eval #(
      .NUM_SIGNALS  (NUM_SIGNALS),
      .CHILD_SIGNAL (CHILD_SIGNAL),
      .KILL_SIGNAL  (KILL_SIGNAL),
      .STOP_SIGNAL  (STOP_SIGNAL)
   ) u_eval (
      .item_i (req_item_ff),
      .pend_i (pend_ff),
      .disp_i (disp_ff),
      .pend_o (pend_next),
      .disp_o (disp_next),
      .rsp_o  (rsp_next)
   );

   // Signal state: updated as the request moves to the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         for (int i = 0; i < NSIG; i++) begin
            disp_ff[i] <= DISP_DEFAULT;
         end
      end else if (advance) begin
         pend_ff <= pend_next;
         disp_ff <= disp_next;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_item_ff <= rsp_next;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.error         = rsp_item_ff.error;
   assign rsp_if.deliverable   = rsp_item_ff.deliverable;
   assign rsp_if.signal_out    = rsp_item_ff.signal_out;
   assign rsp_if.action        = rsp_item_ff.action;
   assign rsp_if.signal_class  = rsp_item_ff.signal_class;
   assign rsp_if.reap_children = rsp_item_ff.reap_children;
   assign rsp_if.pending_after = rsp_item_ff.pending_after;

`ifndef SYNTHESIS
   // Signal zero can never become pending
   a_no_sig_zero: assert property (@(posedge clock) disable iff (reset)
      !pend_ff[0])
      else $error("signal zero pending");

   // Deliver with anything pending removes exactly one signal
   a_deliver_pops_one: assert property (@(posedge clock) disable iff (reset)
      (advance && req_item_ff.mode == MODE_DELIVER && pend_ff != '0) |=>
      ($countones(pend_ff) == $countones($past(pend_ff)) - 1))
      else $error("deliver did not remove exactly one pending signal");

   // A check that finds nothing deliverable leaves nothing pending
   a_check_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && req_item_ff.mode == MODE_CHECK) |=>
      (rsp_item_ff.deliverable || pend_ff == '0))
      else $error("check left undeliverable signals pending");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for signal_pending_dispatcher (post, set disposition,
// check and deliver), directed table then random traffic with random stalls on both sides.
// Depends on spd_pkg, spd_req_if, spd_rsp_if and the RTL of the block.

module testbench;
   import spd_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int RANDOM_ITEMS = 1575;
   localparam int LONG_HOLD    = 150;
   localparam int DRAIN_CYCLES = 8;

   // Class of each signal, signal 19 in the top slot down to signal 0
   localparam logic [3*20-1:0] CLASS_BY_SIG = {
      CLS_TTY, CLS_TERM, CLS_USER, CLS_USER, CLS_TERM, CLS_USER, CLS_SYSERR,
      CLS_SYSERR, CLS_EXCEPTION, CLS_EXCEPTION, CLS_TERM, CLS_EXCEPTION,
      CLS_EXCEPTION, CLS_EXCEPTION, CLS_TRACE, CLS_EXCEPTION, CLS_TTY, CLS_TTY,
      CLS_TTY, CLS_NONE};
   // Signals whose default action dumps core: 3 to 8 and 10 to 12
   localparam logic [19:0] CORE_DUMP_SIGS = 20'h01DF8;

   typedef struct {
      req_item_type stim;
      bit           typed;
      rsp_item_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   spd_req_if req_bus ();
   spd_rsp_if rsp_bus ();

   signal_pending_dispatcher u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // Shadow state of the dispatcher
   logic [PEND_OUT_W-1:0] pend_mask;
   logic [DISP_W-1:0]     disp_of [0:31];

   rsp_item_type awaited_outcomes [$];
   stim_row_type directed_rows [$];

   int  mismatches    = 0;
   int  results_seen  = 0;
   int  cycle_count   = 0;
   bit  send_burst    = 1'b0;
   bit  recv_burst    = 1'b0;
   bit  long_hold     = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic bit sig_valid(input logic [SIG_W-1:0] sig);
      return sig >= 1 && sig <= NUM_SIGNALS_DEF;
   endfunction

   // Works out the response to one request and advances the shadow state
   function automatic rsp_item_type dispatch_outcome(input req_item_type it);
      rsp_item_type r;
      int           s;
      bit           stop;
      r    = '0;
      stop = 1'b0;
      case (it.mode)
         MODE_POST: begin
            if (sig_valid(it.signal_number)) pend_mask[it.signal_number] = 1'b1;
            else r.error = 1'b1;
         end
         MODE_SET_DISP: begin
            if (!sig_valid(it.signal_number) || it.signal_number == KILL_SIGNAL_DEF ||
                it.signal_number == STOP_SIGNAL_DEF)
               r.error = 1'b1;
            else
               disp_of[it.signal_number] = (it.disposition > DISP_CATCH) ? DISP_CATCH
                                                                         : it.disposition;
         end
         MODE_CHECK: begin
            // walk upwards, dropping what cannot be delivered
            for (s = 1; s <= NUM_SIGNALS_DEF; s++) begin
               if (!stop && pend_mask[s]) begin
                  if (s == CHILD_SIGNAL_DEF) begin
                     if (disp_of[s] == DISP_IGNORE) r.reap_children = 1'b1;
                     else if (disp_of[s] != DISP_DEFAULT) stop = 1'b1;
                  end else if (disp_of[s] != DISP_IGNORE) begin
                     stop = 1'b1;
                  end
                  if (stop) r.deliverable = 1'b1;
                  else pend_mask[s] = 1'b0;
               end
            end
         end
         default: begin
            for (s = 1; s <= NUM_SIGNALS_DEF; s++) begin
               if (!stop && pend_mask[s]) begin
                  stop           = 1'b1;
                  pend_mask[s]   = 1'b0;
                  r.signal_out   = s[SIG_W-1:0];
                  r.signal_class = CLASS_BY_SIG[3*s +: 3];
                  if (disp_of[s] == DISP_IGNORE) begin
                     r.action = ACT_IGNORED;
                  end else if (disp_of[s] != DISP_DEFAULT) begin
                     disp_of[s] = DISP_DEFAULT;
                     r.action   = ACT_HANDLER;
                  end else if (CORE_DUMP_SIGS[s]) begin
                     r.action = ACT_CORE_EXIT;
                  end else begin
                     r.action = ACT_EXIT;
                  end
               end
            end
         end
      endcase
      r.pending_after = pend_mask;
      return r;
   endfunction

   function automatic rsp_item_type plain_rsp(input logic err, input logic [SIG_W-1:0] sig,
                                              input logic [ACTION_W-1:0] act,
                                              input logic [CLASS_W-1:0] cls,
                                              input logic [PEND_OUT_W-1:0] pend);
      rsp_item_type r;
      r               = '0;
      r.error         = err;
      r.signal_out    = sig;
      r.action        = act;
      r.signal_class  = cls;
      r.pending_after = pend;
      return r;
   endfunction

   function automatic stim_row_type row(input mode_type m, input int sig, input int disp,
                                        input bit typed, input rsp_item_type want);
      stim_row_type t;
      t.stim.mode          = m;
      t.stim.signal_number = sig[SIG_W-1:0];
      t.stim.disposition   = disp[DISP_W-1:0];
      t.typed              = typed;
      t.want               = want;
      return t;
   endfunction

   // Random request: mostly in-range signals, with the special ones and noise mixed in
   function automatic req_item_type random_request();
      req_item_type it;
      int           pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)      it.mode = MODE_POST;
      else if (pick < 55) it.mode = MODE_SET_DISP;
      else if (pick < 75) it.mode = MODE_CHECK;
      else                it.mode = MODE_DELIVER;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         case ($urandom_range(0, 2))
            0:       it.signal_number = KILL_SIGNAL_DEF;
            1:       it.signal_number = CHILD_SIGNAL_DEF;
            default: it.signal_number = STOP_SIGNAL_DEF;
         endcase
      end else if (pick < 85) begin
         it.signal_number = $urandom_range(1, NUM_SIGNALS_DEF);
      end else begin
         it.signal_number = $urandom_range(0, 31);
      end
      it.disposition = $urandom_range(0, 3);
      return it;
   endfunction

   // Offers one request and waits for its transfer
   task automatic send_request(input req_item_type it, input bit typed,
                               input rsp_item_type typed_want);
      int           gap;
      rsp_item_type want;
      gap = (send_burst || long_hold) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.mode          <= it.mode;
      req_bus.signal_number <= it.signal_number;
      req_bus.disposition   <= it.disposition;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      want = dispatch_outcome(it);
      awaited_outcomes.push_back(typed ? typed_want : want);
   endtask

   task automatic compare_field(input string fname, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result %0d: %s expected %0h, got %0h", results_seen, fname, want, got);
      end
   endtask

   // Stimulus
   initial begin
      int i;
      req_bus.valid         = 1'b0;
      req_bus.mode          = MODE_POST;
      req_bus.signal_number = '0;
      req_bus.disposition   = DISP_DEFAULT;
      pend_mask             = '0;
      for (i = 0; i < 32; i++) disp_of[i] = DISP_DEFAULT;

      // idle block: empty deliver and check, range errors, refused dispositions, then two posts and a deliver
      directed_rows.push_back(row(MODE_DELIVER, 0, 0, 1, '0));
      directed_rows.push_back(row(MODE_CHECK, 0, 0, 1, '0));
      directed_rows.push_back(row(MODE_POST, 0, 0, 1, plain_rsp(1, 0, ACT_NONE, CLS_NONE, 0)));
      directed_rows.push_back(row(MODE_POST, 31, 3, 1, plain_rsp(1, 0, ACT_NONE, CLS_NONE, 0)));
      directed_rows.push_back(row(MODE_POST, 20, 0, 1, plain_rsp(1, 0, ACT_NONE, CLS_NONE, 0)));
      directed_rows.push_back(row(MODE_SET_DISP, KILL_SIGNAL_DEF, DISP_IGNORE, 1,
                                  plain_rsp(1, 0, ACT_NONE, CLS_NONE, 0)));
      directed_rows.push_back(row(MODE_SET_DISP, STOP_SIGNAL_DEF, DISP_CATCH, 1,
                                  plain_rsp(1, 0, ACT_NONE, CLS_NONE, 0)));
      directed_rows.push_back(row(MODE_POST, 1, 0, 1,
                                  plain_rsp(0, 0, ACT_NONE, CLS_NONE, 20'h00002)));
      directed_rows.push_back(row(MODE_POST, 19, 0, 1,
                                  plain_rsp(0, 0, ACT_NONE, CLS_NONE, 20'h80002)));
      directed_rows.push_back(row(MODE_DELIVER, 0, 0, 1,
                                  plain_rsp(0, 1, ACT_EXIT, CLS_TTY, 20'h80000)));
      // handler resets to default; disposition code three means catch
      directed_rows.push_back(row(MODE_SET_DISP, 3, 3, 0, '0));
      directed_rows.push_back(row(MODE_POST, 3, 0, 0, '0));
      directed_rows.push_back(row(MODE_DELIVER, 0, 0, 0, '0));
      directed_rows.push_back(row(MODE_POST, 3, 0, 0, '0));
      directed_rows.push_back(row(MODE_DELIVER, 0, 0, 0, '0));
      // ignored delivery, then check dropping ignored signals and the child
      directed_rows.push_back(row(MODE_SET_DISP, 5, DISP_IGNORE, 0, '0));
      directed_rows.push_back(row(MODE_POST, 5, 0, 0, '0));
      directed_rows.push_back(row(MODE_DELIVER, 0, 0, 0, '0));
      directed_rows.push_back(row(MODE_POST, 5, 0, 0, '0));
      directed_rows.push_back(row(MODE_SET_DISP, CHILD_SIGNAL_DEF, DISP_IGNORE, 0, '0));
      directed_rows.push_back(row(MODE_POST, CHILD_SIGNAL_DEF, 0, 0, '0));
      directed_rows.push_back(row(MODE_CHECK, 0, 0, 0, '0));
      directed_rows.push_back(row(MODE_SET_DISP, CHILD_SIGNAL_DEF, DISP_DEFAULT, 0, '0));
      directed_rows.push_back(row(MODE_POST, CHILD_SIGNAL_DEF, 0, 0, '0));
      directed_rows.push_back(row(MODE_CHECK, 0, 0, 0, '0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k])
         send_request(directed_rows[k].stim, directed_rows[k].typed, directed_rows[k].want);

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0) send_burst = ($urandom_range(0, 2) == 0);
         // let the block drain completely once
         if (i == RANDOM_ITEMS / 2) begin
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (awaited_outcomes.size() != 0);
         end
         send_request(random_request(), 1'b0, '0);
      end
      req_bus.valid <= 1'b0;

      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaited_outcomes.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Response side: random stalls, two long hold-offs, field-by-field check
   initial begin
      int           stall;
      rsp_item_type got;
      rsp_item_type want;
      rsp_bus.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (results_seen % 100 == 0) recv_burst = ($urandom_range(0, 2) == 0);
         stall = recv_burst ? 0 : $urandom_range(0, 18);
         if (results_seen == 400 || results_seen == 1200) begin
            stall     = LONG_HOLD;
            long_hold = 1'b1;
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         long_hold      = 1'b0;
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);

         got.error         = rsp_bus.error;
         got.deliverable   = rsp_bus.deliverable;
         got.signal_out    = rsp_bus.signal_out;
         got.action        = rsp_bus.action;
         got.signal_class  = rsp_bus.signal_class;
         got.reap_children = rsp_bus.reap_children;
         got.pending_after = rsp_bus.pending_after;

         if (awaited_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d: transfer with nothing outstanding", results_seen);
         end else begin
            want = awaited_outcomes.pop_front();
            compare_field("error", want.error, got.error);
            compare_field("deliverable", want.deliverable, got.deliverable);
            compare_field("signal_out", want.signal_out, got.signal_out);
            compare_field("action", want.action, got.action);
            compare_field("signal_class", want.signal_class, got.signal_class);
            compare_field("reap_children", want.reap_children, got.reap_children);
            compare_field("pending_after", want.pending_after, got.pending_after);
         end
         results_seen++;
      end
   end

endmodule

/* files.f */
rtl/spd_pkg.sv
rtl/spd_req_if.sv
rtl/spd_rsp_if.sv
rtl/spd_eval.sv
rtl/signal_pending_dispatcher.sv
tb/testbench.sv
